// ===== hw/rtl/peak_meter_falloff_deflection_defines.svh =====
// Assertion macros shared by the peak meter checker.
// Included by file name from the checker file; needs nothing else.
`ifndef PEAK_METER_FALLOFF_DEFLECTION_DEFINES_SVH
`define PEAK_METER_FALLOFF_DEFLECTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PMFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PMFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pmfd_pkg.sv =====
// Shared constants and stage hand-over types of the peak meter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pmfd_pkg;

   // Log2 format: signed integer part above a 24-bit fraction.
   localparam int FRAC_BITS  = 24;
   localparam int UNITY_LOG2 = 20;
   localparam int IPART_W    = 6;
   localparam int LOG_W      = IPART_W + FRAC_BITS;
   localparam int M_W        = 32;

   // Decibel scaling: 20*log10(2) in Q.28. The Q8.8 LSB sits at bit 44,
   // so half of it, at bit 43, is added before truncation.
   localparam int DB_W   = 16;
   localparam int PROD_W = LOG_W + 32;
   localparam int DB_LSB = 44;
   localparam logic signed [31:0]       DB_K     = 32'sd1616142483;
   localparam logic signed [PROD_W-1:0] DB_ROUND = PROD_W'(1) << (DB_LSB - 1);
   localparam logic signed [DB_W-1:0]   DB_FLOOR = 16'sh8000;

   // Fall-off register.
   localparam int DECAY_W = 13;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 13'd1336;

   // Deflection: curve value and division by 230 through a reciprocal of 115.
   localparam int DEF_W       = 17;
   localparam int DIV_X_W     = DEF_W + 6;
   localparam int RECIP_K_W   = 24;
   localparam int RECIP_W     = DIV_X_W + RECIP_K_W;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_K_W-1:0] RECIP_115 = 24'd9336886;
   localparam logic [5:0]           HALF_DIV  = 6'd57;
   localparam int DEFL_W = 16;
   localparam logic [DEFL_W-1:0] DEFL_FULL = 16'hFFFF;

   // Result word of the log2 unit.
   typedef struct packed {
      logic                       zero;
      logic signed [IPART_W-1:0]  ipart;
      logic [FRAC_BITS-1:0]       frac;
   } pmfd_log_type;

   // Result word of the decibel scaler.
   typedef struct packed {
      logic                    zero;
      logic signed [DB_W-1:0]  db;
   } pmfd_db_type;

endpackage

// ===== hw/rtl/pmfd_log2.sv =====
// Pipelined log2 of the linear level: top-bit search, normalisation and
// one squaring stage per fraction bit. Depends on pmfd_pkg.
`timescale 1ns / 1ps

module pmfd_log2 #(
   parameter int LEVEL_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [LEVEL_BITS-1:0]  in_level,
   output logic                   out_valid,
   output pmfd_pkg::pmfd_log_type out_log
);
   import pmfd_pkg::*;

   localparam int EW   = $clog2(LEVEL_BITS);
   localparam int NSTG = FRAC_BITS;

   logic [EW-1:0]         top_in;
   logic [EW-1:0]         top_ff;
   logic [LEVEL_BITS-1:0] lvl_ff;
   logic                  vld_a_ff;
   logic [4:0]            shamt;
   logic [M_W-1:0]        m0_in;
   pmfd_log_type          lg0_in;

   logic [M_W-1:0]        m_ff  [0:NSTG];
   pmfd_log_type          lg_ff [0:NSTG];
   logic [NSTG:0]         vld_ff;

   logic [2*M_W-1:0]      sq     [0:NSTG-1];
   logic [M_W:0]          t      [0:NSTG-1];
   logic [M_W-1:0]        m_in   [0:NSTG-1];
   pmfd_log_type          lg_in  [0:NSTG-1];

   // Index of the highest set bit of the level.
   always_comb begin
      top_in = '0;
      for (int i = 0; i < LEVEL_BITS; i++) begin
         if (in_level[i]) begin
            top_in = EW'(i);
         end
      end
   end

   // Normalise to a Q1.31 mantissa and form the integer part of the log.
   assign shamt = 5'd31 - 5'(top_ff);
   assign m0_in = 32'(lvl_ff) << shamt;

   always_comb begin
      lg0_in.zero  = (lvl_ff == '0);
      lg0_in.ipart = IPART_W'(top_ff) - IPART_W'(UNITY_LOG2);
      lg0_in.frac  = '0;
   end

   // Each squaring stage yields one fraction bit, most significant first.
   always_comb begin
      for (int k = 0; k < NSTG; k++) begin
         sq[k]    = (2*M_W)'(m_ff[k]) * (2*M_W)'(m_ff[k]);
         t[k]     = sq[k][2*M_W-1:M_W-1];
         lg_in[k] = lg_ff[k];
         if (t[k][M_W]) begin
            m_in[k] = t[k][M_W:1];
            lg_in[k].frac[NSTG-1-k] = 1'b1;
         end else begin
            m_in[k] = t[k][M_W-1:0];
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         top_ff   <= top_in;
         lvl_ff   <= in_level;
         m_ff[0]  <= m0_in;
         lg_ff[0] <= lg0_in;
         for (int k = 0; k < NSTG; k++) begin
            m_ff[k+1]  <= m_in[k];
            lg_ff[k+1] <= lg_in[k];
         end
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_ff   <= '0;
      end else if (adv) begin
         vld_a_ff <= in_valid;
         vld_ff   <= {vld_ff[NSTG-1:0], vld_a_ff};
      end
   end

   assign out_valid = vld_ff[NSTG];
   assign out_log   = lg_ff[NSTG];

endmodule

// ===== hw/rtl/pmfd_to_db.sv =====
// Scales the log2 value to decibels in Q8.8 with round-half-up.
// Depends on pmfd_pkg.
`timescale 1ns / 1ps

module pmfd_to_db (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  pmfd_pkg::pmfd_log_type in_log,
   output logic                   out_valid,
   output pmfd_pkg::pmfd_db_type  out_db
);
   import pmfd_pkg::*;

   logic signed [LOG_W-1:0]  lg;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] sum;
   logic                     zero_ff;
   logic                     vld_p_ff;
   logic                     vld_d_ff;
   pmfd_db_type              db_in;
   pmfd_db_type              db_ff;

   // Multiply by 20*log10(2).
   assign lg      = {in_log.ipart, in_log.frac};
   assign prod_in = lg * DB_K;

   // Round and take the Q8.8 bits.
   always_comb begin
      sum        = prod_ff + DB_ROUND;
      db_in.db   = sum[DB_LSB+DB_W-1:DB_LSB];
      db_in.zero = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         zero_ff <= in_log.zero;
         db_ff   <= db_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
         vld_d_ff <= 1'b0;
      end else if (adv) begin
         vld_p_ff <= in_valid;
         vld_d_ff <= vld_p_ff;
      end
   end

   assign out_valid = vld_d_ff;
   assign out_db    = db_ff;

endmodule

// ===== hw/rtl/pmfd_deflect.sv =====
// Maps the held level onto the eight-segment meter curve and scales it
// to a Q0.16 fraction; holds the output register. Depends on pmfd_pkg.
`timescale 1ns / 1ps

module pmfd_deflect (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [pmfd_pkg::DB_W-1:0] in_held,
   output logic                            out_valid,
   output logic [pmfd_pkg::DEFL_W-1:0]     out_defl,
   output logic signed [pmfd_pkg::DB_W-1:0] out_held
);
   import pmfd_pkg::*;

   // Segment starts in Q8.8 dB.
   localparam logic signed [DB_W-1:0] SEG_M70 = -16'sd17920;
   localparam logic signed [DB_W-1:0] SEG_M60 = -16'sd15360;
   localparam logic signed [DB_W-1:0] SEG_M50 = -16'sd12800;
   localparam logic signed [DB_W-1:0] SEG_M40 = -16'sd10240;
   localparam logic signed [DB_W-1:0] SEG_M30 = -16'sd7680;
   localparam logic signed [DB_W-1:0] SEG_M20 = -16'sd5120;
   localparam logic signed [DB_W-1:0] SEG_P6  = 16'sd1536;

   logic [12:0]             r;
   logic [3:0]              k;
   logic [DEF_W-1:0]        base;
   logic                    full_in;
   logic [DEF_W-1:0]        def_in;
   logic [DEF_W-1:0]        def_ff;
   logic                    full_a_ff;
   logic signed [DB_W-1:0]  held_a_ff;
   logic                    vld_a_ff;
   logic [DIV_X_W-1:0]      x;
   logic [RECIP_W-1:0]      recip_in;
   logic [RECIP_W-1:0]      recip_ff;
   logic                    full_b_ff;
   logic signed [DB_W-1:0]  held_b_ff;
   logic                    vld_b_ff;
   logic [DEF_W-1:0]        q;
   logic [DEFL_W-1:0]       defl_in;
   logic [DEFL_W-1:0]       defl_ff;
   logic signed [DB_W-1:0]  held_o_ff;
   logic                    vld_o_ff;

   // Segment select: offset into the segment, slope and start value.
   always_comb begin
      r       = '0;
      k       = 4'd0;
      base    = '0;
      full_in = 1'b0;
      priority if (in_held < SEG_M70) begin
         k = 4'd0;
      end else if (in_held < SEG_M60) begin
         r = 13'(in_held - SEG_M70);
         k = 4'd1;
      end else if (in_held < SEG_M50) begin
         r    = 13'(in_held - SEG_M60);
         k    = 4'd2;
         base = 17'd2560;
      end else if (in_held < SEG_M40) begin
         r    = 13'(in_held - SEG_M50);
         k    = 4'd3;
         base = 17'd7680;
      end else if (in_held < SEG_M30) begin
         r    = 13'(in_held - SEG_M40);
         k    = 4'd6;
         base = 17'd15360;
      end else if (in_held < SEG_M20) begin
         r    = 13'(in_held - SEG_M30);
         k    = 4'd8;
         base = 17'd30720;
      end else if (in_held < SEG_P6) begin
         r    = 13'(in_held - SEG_M20);
         k    = 4'd10;
         base = 17'd51200;
      end else begin
         full_in = 1'b1;
      end
      def_in = DEF_W'(r) * DEF_W'(k) + base;
   end

   // Half of (def * 128 + 115), then division by 115 via reciprocal.
   assign x        = {def_ff, HALF_DIV};
   assign recip_in = RECIP_W'(x) * RECIP_W'(RECIP_115);

   // Quotient with saturation at full scale.
   always_comb begin
      q = recip_ff[RECIP_W-1:RECIP_SHIFT];
      if (full_b_ff || q[DEF_W-1]) begin
         defl_in = DEFL_FULL;
      end else begin
         defl_in = q[DEFL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         def_ff    <= def_in;
         full_a_ff <= full_in;
         held_a_ff <= in_held;
         recip_ff  <= recip_in;
         full_b_ff <= full_a_ff;
         held_b_ff <= held_a_ff;
         defl_ff   <= defl_in;
         held_o_ff <= held_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_o_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
         vld_o_ff <= vld_b_ff;
      end
   end

   assign out_valid = vld_o_ff;
   assign out_defl  = defl_ff;
   assign out_held  = held_o_ff;

endmodule

// ===== hw/rtl/peak_meter_falloff_deflection.sv =====
// Peak meter with bounded fall-off and a piecewise-linear meter deflection.
// Each req transfer carries one linear level (2^20 is 0 dB); each rsp
// transfer returns the held peak in Q8.8 dB and the deflection in Q0.16.
// The block takes one level per clock while no rsp is held. Each result
// passes the input register, the log2 unit, which has one 32x32 squaring
// multiplier per fraction bit (24 stages), the decibel scaling, the peak
// hold and the deflection stages. All stages advance together, so a held
// rsp stalls the whole pipeline and req_tready follows. The fall-off step
// may be written through the csr channel at any time the block is idle.
// Depends on pmfd_pkg and its submodules pmfd_log2, pmfd_to_db and
// pmfd_deflect.
`timescale 1ns / 1ps

module peak_meter_falloff_deflection #(
   parameter int  LEVEL_BITS = 24,
   localparam int REQ_W      = ((LEVEL_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // Level input.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,   // level
   // Result output.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // held_db (high half), deflection (low half)
   // Fall-off step register.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmfd_pkg::DECAY_W-1:0]      csr_data
);
   import pmfd_pkg::*;

   logic                    adv;
   logic [LEVEL_BITS-1:0]   lvl_ff;
   logic                    in_vld_ff;
   logic                    log_vld;
   pmfd_log_type            log_w;
   logic                    db_vld;
   pmfd_db_type             db_w;
   logic [DECAY_W-1:0]      decay_ff;
   logic signed [DB_W-1:0]  db_s;
   logic signed [DB_W:0]    lowest;
   logic signed [DB_W-1:0]  fall_lim;
   logic signed [DB_W-1:0]  held_in;
   logic signed [DB_W-1:0]  held_ff;
   logic                    hold_vld_ff;
   logic [DEFL_W-1:0]       defl;
   logic signed [DB_W-1:0]  held_out;

   // Pipeline moves whenever the output register is empty or being taken.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // Fall-off step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
      end else if (csr_valid) begin
         decay_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (adv) begin
         lvl_ff <= req_tdata[LEVEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_tvalid;
      end
   end

   pmfd_log2 #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_vld_ff),
      .in_level  (lvl_ff),
      .out_valid (log_vld),
      .out_log   (log_w)
   );

   pmfd_to_db u_to_db (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (log_vld),
      .in_log    (log_w),
      .out_valid (db_vld),
      .out_db    (db_w)
   );

   // Peak hold: a falling level drops by at most the step, down to the floor.
   always_comb begin
      db_s   = db_w.zero ? DB_FLOOR : db_w.db;
      lowest = {held_ff[DB_W-1], held_ff} - (DB_W+1)'(decay_ff);
      if (lowest[DB_W] != lowest[DB_W-1]) begin
         fall_lim = DB_FLOOR;
      end else begin
         fall_lim = lowest[DB_W-1:0];
      end
      if (db_s < held_ff && db_s < fall_lim) begin
         held_in = fall_lim;
      end else begin
         held_in = db_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= DB_FLOOR;
         hold_vld_ff <= 1'b0;
      end else if (adv) begin
         hold_vld_ff <= db_vld;
         if (db_vld) begin
            held_ff <= held_in;
         end
      end
   end

   pmfd_deflect u_deflect (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (hold_vld_ff),
      .in_held   (held_ff),
      .out_valid (rsp_tvalid),
      .out_defl  (defl),
      .out_held  (held_out)
   );

   assign rsp_tdata = {held_out, defl};

endmodule

// ===== hw/rtl/pmfd_checker.sv =====
// Port-level checks of the peak meter, bound to its top level.
// Depends on the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "peak_meter_falloff_deflection_defines.svh"

module pmfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   localparam logic signed [15:0] FULL_DB = 16'sd1536;
   localparam logic signed [15:0] REST_DB = -16'sd17920;

   logic               stall;
   logic signed [15:0] held;
   logic [15:0]        defl;
   logic               full_seen;
   logic               rest_seen;

   // Result fields and the conditions that the checks look at.
   assign stall     = rsp_tvalid && !rsp_tready;
   assign held      = $signed(rsp_tdata[31:16]);
   assign defl      = rsp_tdata[15:0];
   assign full_seen = rsp_tvalid && (held >= FULL_DB);
   assign rest_seen = rsp_tvalid && (held < REST_DB);

   // A stalled result keeps its transfer pending and its payload steady.
   `PMFD_ASSERT_NXT(a_hold, clock, reset, stall, rsp_tvalid && $stable(rsp_tdata), "rsp moved")

   // A stalled result freezes the pipeline, so no level is taken.
   `PMFD_ASSERT_IMP(a_stall, clock, reset, stall, !req_tready, "req taken in stall")

   // At or above +6 dB the deflection is at full scale.
   `PMFD_ASSERT_IMP(a_full, clock, reset, full_seen, defl == 16'hFFFF, "deflection not full")

   // Below -70 dB the meter rests at zero.
   `PMFD_ASSERT_IMP(a_rest, clock, reset, rest_seen, defl == 16'h0000, "deflection not zero")

endmodule

bind peak_meter_falloff_deflection pmfd_checker u_pmfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
